// ----- rtl/core/tswc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswc_pkg
// Shared types, codes and helpers of the sender window controller.
// ----------------------------------------------------------------------------
package tswc_pkg;

   localparam int TABLE_DEPTH = 10;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // item kinds
   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_OFFER = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // result actions
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_NEW   = 3'd1,
      ACT_RETX  = 3'd2,
      ACT_RESET = 3'd3,
      ACT_PROBE = 3'd4
   } action_type;

   // register indexes
   localparam logic [2:0] CSR_MSS       = 3'd0;
   localparam logic [2:0] CSR_INIT_SEQ  = 3'd1;
   localparam logic [2:0] CSR_INIT_RTO  = 3'd2;
   localparam logic [2:0] CSR_PROBE     = 3'd3;
   localparam logic [2:0] CSR_DUP_LIMIT = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACK_RD,
      ST_ACK_EV,
      ST_ACK_RTT,
      ST_DUP_RD,
      ST_DUP_EV,
      ST_TICK_RD,
      ST_TICK_EV,
      ST_PROBE,
      ST_SEND,
      ST_FINISH
   } state_type;

   // one outstanding segment
   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] len;
      logic [31:0] stamp;
   } seg_entry_type;

   // serial number order: a is after b
   function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

endpackage

// ----- rtl/core/tswc_seg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswc_seg_ram
// Segment table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tswc_seg_ram
   import tswc_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  seg_entry_type        wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output seg_entry_type        rd_data
);

   seg_entry_type mem_ff [TABLE_DEPTH];
   seg_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tswc_rtt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswc_rtt
// Round trip estimator: four phases per sample, est, deviation, timeout.
// ----------------------------------------------------------------------------
module tswc_rtt
   import tswc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [15:0] load_value,
   input  logic        sample_go,
   input  logic [31:0] sample,
   output logic        rtt_busy,
   output logic [31:0] rto
);

   logic        active_ff, active_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] s_ff, s_in;
   logic [31:0] est_ff, est_in;
   logic [31:0] dev_ff, dev_in;
   logic [31:0] rto_ff, rto_in;
   logic [31:0] diff_ff, diff_in;
   logic [35:0] est_sum;
   logic [33:0] dev_sum;
   logic [34:0] rto_sum;

   // one step per phase
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      s_in      = s_ff;
      est_in    = est_ff;
      dev_in    = dev_ff;
      rto_in    = rto_ff;
      diff_in   = diff_ff;
      est_sum   = {1'b0, est_ff, 3'b000} - {4'd0, est_ff} + {4'd0, s_ff};
      dev_sum   = {1'b0, dev_ff, 1'b0} + {2'd0, dev_ff} + {2'd0, diff_ff};
      rto_sum   = {3'd0, est_ff} + {1'b0, dev_ff, 2'b00};
      if (active_ff) begin
         phase_in = phase_ff + 2'd1;
         unique case (phase_ff)
            2'd0: est_in = est_sum[34:3];
            2'd1: diff_in = (s_ff >= est_ff) ? s_ff - est_ff : est_ff - s_ff;
            2'd2: dev_in = dev_sum[33:2];
            2'd3: begin
               rto_in    = (rto_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : rto_sum[31:0];
               active_in = 1'b0;
            end
            default: ;
         endcase
      end else if (sample_go) begin
         active_in = 1'b1;
         phase_in  = 2'd0;
         s_in      = sample;
      end
      if (load) begin
         est_in = {16'd0, load_value};
         rto_in = {16'd0, load_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 2'd0;
         est_ff    <= 32'd1000;
         dev_ff    <= 32'd0;
         rto_ff    <= 32'd1000;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         est_ff    <= est_in;
         dev_ff    <= dev_in;
         rto_ff    <= rto_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      diff_ff <= diff_in;
   end

   assign rtt_busy = active_ff;
   assign rto      = rto_ff;

endmodule

// ----- rtl/core/tcp_sender_window_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_sender_window_controller
// Sender window control: ACK handling, timeouts, probes and segmentation.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its words then come
// out on rsp_* one per strobe, the last one flagged by rsp_last, and the
// receiver must take each word in the cycle it shows. The segment table is
// walked one entry at a time through a memory with a registered read port:
// each valid entry is read and then evaluated, a segment freed by an ACK
// also waits for the round trip update, each new segment sent takes a step
// and one more step stops sending, and a finish step registers the final
// word. The next item can be taken in the cycle busy falls.
module tcp_sender_window_controller
   import tswc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_ack_number,
   input  logic [15:0] req_peer_window,
   input  logic [15:0] req_offered_bytes,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_seq_number,
   output logic [15:0] rsp_seg_length,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   state_type     state_ff, state_in;
   logic [31:0]   ack_ff, ack_in;
   logic [31:0]   now_ff, now_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]   next_seq_ff, next_seq_in;
   logic [31:0]   last_acked_ff, last_acked_in;
   logic [31:0]   cwnd_ff, cwnd_in;
   logic [15:0]   rwin_ff, rwin_in;
   logic [3:0]    dup_ff, dup_in;
   logic [31:0]   probe_time_ff, probe_time_in;
   logic [31:0]   probe_int_ff, probe_int_in;
   logic [31:0]   bif_ff, bif_in;
   logic [31:0]   bw_ff, bw_in;
   logic          reset_sent_ff, reset_sent_in;
   logic [15:0]   mss_ff, mss_in;
   logic [31:0]   iseq_ff, iseq_in;
   logic [15:0]   irto_ff, irto_in;
   logic [15:0]   fprobe_ff, fprobe_in;
   logic [3:0]    dlim_ff, dlim_in;
   logic          pend_v_ff, pend_v_in;
   action_type    pend_act_ff, pend_act_in;
   logic [31:0]   pend_seq_ff, pend_seq_in;
   logic [15:0]   pend_len_ff, pend_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   action_type    rsp_act_ff, rsp_act_in;
   logic [31:0]   rsp_seq_ff, rsp_seq_in;
   logic [15:0]   rsp_len_ff, rsp_len_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          emit_go;
   action_type    emit_act;
   logic [31:0]   emit_seq;
   logic [15:0]   emit_len;

   logic          mem_we;
   logic [IDX_W-1:0] mem_waddr;
   seg_entry_type mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   seg_entry_type mem_rdata;

   logic          rtt_go;
   logic [31:0]   rtt_sample;
   logic          rtt_busy;
   logic [31:0]   rto;
   logic          rtt_load;

   logic [32:0]   sum33;
   logic [3:0]    dup_next;
   logic [15:0]   len_a, len_b, seg_len;

   tswc_seg_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tswc_rtt u_rtt (
      .clock      (clock),
      .reset      (reset),
      .load       (rtt_load),
      .load_value (csr_wdata[15:0]),
      .sample_go  (rtt_go),
      .sample     (rtt_sample),
      .rtt_busy   (rtt_busy),
      .rto        (rto)
   );

   assign rtt_load = csr_we && (csr_index == CSR_INIT_RTO);

   // sequencer: next state, table access and result words
   always_comb begin
      state_in      = state_ff;
      ack_in        = ack_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      cnt_in        = cnt_ff;
      next_seq_in   = next_seq_ff;
      last_acked_in = last_acked_ff;
      cwnd_in       = cwnd_ff;
      rwin_in       = rwin_ff;
      dup_in        = dup_ff;
      probe_time_in = probe_time_ff;
      probe_int_in  = probe_int_ff;
      bif_in        = bif_ff;
      bw_in         = bw_ff;
      reset_sent_in = reset_sent_ff;
      mss_in        = mss_ff;
      iseq_in       = iseq_ff;
      irto_in       = irto_ff;
      fprobe_in     = fprobe_ff;
      dlim_in       = dlim_ff;
      pend_v_in     = pend_v_ff;
      pend_act_in   = pend_act_ff;
      pend_seq_in   = pend_seq_ff;
      pend_len_in   = pend_len_ff;
      rsp_valid_in  = 1'b0;
      rsp_act_in    = rsp_act_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      emit_go       = 1'b0;
      emit_act      = ACT_NONE;
      emit_seq      = 32'd0;
      emit_len      = 16'd0;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IDX_W-1:0];
      mem_wdata     = mem_rdata;
      mem_raddr     = idx_ff[IDX_W-1:0];
      rtt_go        = 1'b0;
      rtt_sample    = now_ff - mem_rdata.stamp;
      sum33         = 33'd0;
      dup_next      = dup_ff + 4'd1;
      len_a         = (bw_ff < {16'd0, mss_ff}) ? bw_ff[15:0] : mss_ff;
      len_b         = (cwnd_ff < {16'd0, rwin_ff}) ? cwnd_ff[15:0] : rwin_ff;
      seg_len       = (len_a < len_b) ? len_a : len_b;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ack_in = req_ack_number;
               now_in = req_now_ms;
               idx_in = '0;
               wr_in  = '0;
               if (reset_sent_ff || req_kind == KIND_NONE) begin
                  state_in = ST_FINISH;
               end else if (req_kind == KIND_OFFER) begin
                  sum33    = {1'b0, bw_ff} + {17'd0, req_offered_bytes};
                  bw_in    = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                  state_in = ST_SEND;
               end else if (req_kind == KIND_TICK) begin
                  state_in = ST_TICK_RD;
               end else begin
                  // window update and probe timer
                  rwin_in = req_peer_window;
                  if (req_peer_window == 16'd0) begin
                     probe_time_in = req_now_ms;
                     if (probe_int_ff == 32'd0) probe_int_in = {16'd0, fprobe_ff};
                  end else begin
                     probe_int_in = 32'd0;
                  end
                  priority if (seq_after(req_ack_number, next_seq_ff)) begin
                     emit_go       = 1'b1;
                     emit_act      = ACT_RESET;
                     emit_seq      = next_seq_ff;
                     reset_sent_in = 1'b1;
                     state_in      = ST_FINISH;
                  end else if (seq_after(req_ack_number, last_acked_ff)) begin
                     last_acked_in = req_ack_number;
                     dup_in        = 4'd0;
                     sum33         = {1'b0, cwnd_ff} + {17'd0, mss_ff};
                     cwnd_in       = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                     state_in      = ST_ACK_RD;
                  end else if (req_ack_number == last_acked_ff) begin
                     if (dup_next == dlim_ff) begin
                        dup_in   = 4'd0;
                        state_in = ST_DUP_RD;
                     end else begin
                        dup_in   = dup_next;
                        state_in = ST_SEND;
                     end
                  end else begin
                     state_in = ST_SEND;
                  end
               end
            end
         end

         // free acknowledged segments, compact the rest to the front
         ST_ACK_RD: begin
            if (idx_ff == cnt_ff) begin
               cnt_in   = wr_ff;
               state_in = ST_SEND;
            end else begin
               state_in = ST_ACK_EV;
            end
         end
         ST_ACK_EV: begin
            idx_in = idx_ff + CNT_W'(1);
            if (seq_after(ack_ff, mem_rdata.seq)) begin
               rtt_go   = 1'b1;
               bif_in   = (bif_ff >= {16'd0, mem_rdata.len}) ?
                          bif_ff - {16'd0, mem_rdata.len} : 32'd0;
               state_in = ST_ACK_RTT;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = wr_ff[IDX_W-1:0];
               wr_in     = wr_ff + CNT_W'(1);
               state_in  = ST_ACK_RD;
            end
         end
         ST_ACK_RTT: begin
            if (!rtt_busy) state_in = ST_ACK_RD;
         end

         // fast retransmit search
         ST_DUP_RD: begin
            state_in = (idx_ff == cnt_ff) ? ST_SEND : ST_DUP_EV;
         end
         ST_DUP_EV: begin
            if (mem_rdata.seq == ack_ff) begin
               emit_go         = 1'b1;
               emit_act        = ACT_RETX;
               emit_seq        = mem_rdata.seq;
               emit_len        = mem_rdata.len;
               mem_we          = 1'b1;
               mem_wdata.stamp = now_ff;
               cwnd_in         = {1'b0, cwnd_ff[31:1]};
               state_in        = ST_SEND;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_DUP_RD;
            end
         end

         // timeout scan
         ST_TICK_RD: begin
            state_in = (idx_ff == cnt_ff) ? ST_PROBE : ST_TICK_EV;
         end
         ST_TICK_EV: begin
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_TICK_RD;
            if ((now_ff - mem_rdata.stamp) > rto) begin
               emit_go         = 1'b1;
               emit_act        = ACT_RETX;
               emit_seq        = mem_rdata.seq;
               emit_len        = mem_rdata.len;
               mem_we          = 1'b1;
               mem_wdata.stamp = now_ff;
               cwnd_in         = {16'd0, mss_ff};
            end
         end

         // zero window probe
         ST_PROBE: begin
            state_in = ST_SEND;
            if (rwin_ff == 16'd0 && (now_ff - probe_time_ff) > probe_int_ff) begin
               emit_go       = 1'b1;
               emit_act      = ACT_PROBE;
               emit_seq      = next_seq_ff - 32'd1;
               emit_len      = 16'd1;
               probe_time_in = now_ff;
               sum33         = {1'b0, probe_int_ff} + {1'b0, probe_int_ff};
               probe_int_in  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
            end
         end

         // cut waiting bytes into segments, one per cycle
         ST_SEND: begin
            if (cnt_ff == CNT_W'(TABLE_DEPTH) || bw_ff == 32'd0 ||
                bif_ff >= {16'd0, rwin_ff} || bif_ff >= cwnd_ff || seg_len == 16'd0) begin
               state_in = ST_FINISH;
            end else begin
               mem_we          = 1'b1;
               mem_waddr       = cnt_ff[IDX_W-1:0];
               mem_wdata.seq   = next_seq_ff;
               mem_wdata.len   = seg_len;
               mem_wdata.stamp = now_ff;
               cnt_in          = cnt_ff + CNT_W'(1);
               bif_in          = bif_ff + {16'd0, seg_len};
               bw_in           = bw_ff - {16'd0, seg_len};
               next_seq_in     = next_seq_ff + {16'd0, seg_len};
               emit_go         = 1'b1;
               emit_act        = ACT_NEW;
               emit_seq        = next_seq_ff;
               emit_len        = seg_len;
            end
         end

         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_act_in   = pend_v_ff ? pend_act_ff : ACT_NONE;
            rsp_seq_in   = pend_v_ff ? pend_seq_ff : 32'd0;
            rsp_len_in   = pend_v_ff ? pend_len_ff : 16'd0;
            pend_v_in    = 1'b0;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      // hold one word back so the final one can carry the last flag
      if (emit_go) begin
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b0;
            rsp_act_in   = pend_act_ff;
            rsp_seq_in   = pend_seq_ff;
            rsp_len_in   = pend_len_ff;
         end
         pend_v_in   = 1'b1;
         pend_act_in = emit_act;
         pend_seq_in = emit_seq;
         pend_len_in = emit_len;
      end

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_MSS: begin
               mss_in  = csr_wdata[15:0];
               cwnd_in = {16'd0, csr_wdata[15:0]};
               rwin_in = csr_wdata[15:0];
            end
            CSR_INIT_SEQ: begin
               iseq_in       = csr_wdata;
               next_seq_in   = csr_wdata;
               last_acked_in = csr_wdata;
            end
            CSR_INIT_RTO:  irto_in   = csr_wdata[15:0];
            CSR_PROBE:     fprobe_in = csr_wdata[15:0];
            CSR_DUP_LIMIT: dlim_in   = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         next_seq_ff   <= 32'd0;
         last_acked_ff <= 32'd0;
         cwnd_ff       <= 32'd1400;
         rwin_ff       <= 16'd1400;
         dup_ff        <= 4'd0;
         probe_time_ff <= 32'd0;
         probe_int_ff  <= 32'd0;
         bif_ff        <= 32'd0;
         bw_ff         <= 32'd0;
         reset_sent_ff <= 1'b0;
         mss_ff        <= 16'd1400;
         iseq_ff       <= 32'd0;
         irto_ff       <= 16'd1000;
         fprobe_ff     <= 16'd1000;
         dlim_ff       <= 4'd3;
         pend_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         next_seq_ff   <= next_seq_in;
         last_acked_ff <= last_acked_in;
         cwnd_ff       <= cwnd_in;
         rwin_ff       <= rwin_in;
         dup_ff        <= dup_in;
         probe_time_ff <= probe_time_in;
         probe_int_ff  <= probe_int_in;
         bif_ff        <= bif_in;
         bw_ff         <= bw_in;
         reset_sent_ff <= reset_sent_in;
         mss_ff        <= mss_in;
         iseq_ff       <= iseq_in;
         irto_ff       <= irto_in;
         fprobe_ff     <= fprobe_in;
         dlim_ff       <= dlim_in;
         pend_v_ff     <= pend_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ack_ff      <= ack_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      wr_ff       <= wr_in;
      pend_act_ff <= pend_act_in;
      pend_seq_ff <= pend_seq_in;
      pend_len_ff <= pend_len_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_act_ff;
   assign rsp_seq_number = rsp_seq_ff;
   assign rsp_seg_length = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;

   // table fill never exceeds its depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("segment count beyond table depth");

   // finishing an item always puts out the final word
   a_finish_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_valid_ff && rsp_last_ff)
      else $error("item finished without final word");

   // a non-final word only shows while the item is still in work
   a_nonfinal_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff != ST_IDLE)
      else $error("non-final word after item completed");

endmodule

// ----- sim/tswc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswc_checker
// Watches the request, response and register ports of the sender window
// controller, predicts every response word and compares it in order.
// ----------------------------------------------------------------------------
module tswc_checker
   import tswc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_ack_number,
   input  logic [15:0] req_peer_window,
   input  logic [15:0] req_offered_bytes,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_action,
   input  logic [31:0] rsp_seq_number,
   input  logic [15:0] rsp_seg_length,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          errors,
   output int          pending,
   output logic [31:0] snd_next,
   output logic [31:0] snd_una
);

   localparam int MAX_WORDS = TABLE_DEPTH + 1;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct {
      action_type  action;
      logic [31:0] seq;
      logic [15:0] len;
      logic        last;
   } word_type;

   word_type expected_words[$];

   // predicted configuration
   logic [31:0] c_mss, c_init_seq, c_init_rto, c_probe;
   logic [3:0]  c_dup_limit;

   // predicted segment table and sender state
   logic [31:0] t_seq [TABLE_DEPTH];
   logic [15:0] t_len [TABLE_DEPTH];
   logic [31:0] t_time [TABLE_DEPTH];
   bit          t_ok [TABLE_DEPTH];
   logic [31:0] nxt, una, cwnd, rwnd, est, dev, rto, p_time, p_ivl, in_flight, waiting;
   logic [3:0]  dups;
   bit          rst_sent;

   word_type    item_words [MAX_WORDS];
   int          n_words;

   function automatic bit serial_after(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 0) && !d[31];
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? ALL_ONES : s[31:0];
   endfunction

   task automatic push_word(action_type act, logic [31:0] seq, logic [31:0] len);
      if (n_words < MAX_WORDS) begin
         item_words[n_words] = '{act, seq, len[15:0], 1'b0};
         n_words++;
      end
   endtask

   task automatic sample_rtt(logic [31:0] s);
      logic [63:0] acc;
      logic [31:0] diff;
      acc = {32'd0, est} * 64'd7 + {32'd0, s};
      est = acc[34:3];
      diff = (s >= est) ? s - est : est - s;
      acc = {32'd0, dev} * 64'd3 + {32'd0, diff};
      dev = acc[33:2];
      acc = {32'd0, est} + {30'd0, dev, 2'b00};
      rto = (acc > {32'd0, ALL_ONES}) ? ALL_ONES : acc[31:0];
   endtask

   task automatic clear_state();
      for (int i = 0; i < TABLE_DEPTH; i++) t_ok[i] = 0;
      c_mss = 1400; c_init_seq = 0; c_init_rto = 1000; c_probe = 1000; c_dup_limit = 3;
      nxt = 0; una = 0; cwnd = 1400; rwnd = 1400; dups = 0;
      est = 1000; dev = 0; rto = 1000; p_time = 0; p_ivl = 0;
      in_flight = 0; waiting = 0; rst_sent = 0;
   endtask

   task automatic on_ack(logic [31:0] ack, logic [15:0] win, logic [31:0] now);
      int j;
      rwnd = {16'd0, win};
      if (win == 0) begin
         p_time = now;
         if (p_ivl == 0) p_ivl = c_probe;
      end else begin
         p_ivl = 0;
      end
      if (serial_after(ack, nxt)) begin
         push_word(ACT_RESET, nxt, 0);
         rst_sent = 1;
      end else if (serial_after(ack, una)) begin
         // free acknowledged segments, keep the rest packed in send order
         una = ack;
         j = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (t_ok[i]) begin
               if (serial_after(ack, t_seq[i])) begin
                  sample_rtt(now - t_time[i]);
                  in_flight = (in_flight >= t_len[i]) ? in_flight - t_len[i] : 0;
               end else begin
                  t_seq[j] = t_seq[i]; t_len[j] = t_len[i]; t_time[j] = t_time[i];
                  t_ok[j] = 1;
                  j++;
               end
            end
         end
         for (int i = j; i < TABLE_DEPTH; i++) t_ok[i] = 0;
         dups = 0;
         cwnd = add_sat(cwnd, c_mss);
      end else if (ack == una) begin
         // duplicate: fast retransmit on reaching the limit
         dups = dups + 4'd1;
         if (dups == c_dup_limit) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (t_ok[i] && t_seq[i] == ack) begin
                  push_word(ACT_RETX, t_seq[i], t_len[i]);
                  t_time[i] = now;
                  cwnd = cwnd >> 1;
                  break;
               end
            end
            dups = 0;
         end
      end
   endtask

   task automatic on_tick(logic [31:0] now);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (t_ok[i] && (now - t_time[i]) > rto) begin
            push_word(ACT_RETX, t_seq[i], t_len[i]);
            t_time[i] = now;
            cwnd = c_mss;
         end
      end
      if (rwnd == 0 && (now - p_time) > p_ivl) begin
         push_word(ACT_PROBE, nxt - 32'd1, 1);
         p_time = now;
         p_ivl = add_sat(p_ivl, p_ivl);
      end
   endtask

   task automatic cut_segments(logic [31:0] now);
      logic [31:0] len;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (!t_ok[s]) begin
            if (waiting == 0 || in_flight >= rwnd || in_flight >= cwnd) break;
            len = waiting;
            if (len > c_mss) len = c_mss;
            if (len > rwnd) len = rwnd;
            if (len > cwnd) len = cwnd;
            if (len == 0) break;
            t_seq[s] = nxt; t_len[s] = len[15:0]; t_time[s] = now; t_ok[s] = 1;
            in_flight = in_flight + len;
            waiting = waiting - len;
            push_word(ACT_NEW, nxt, len);
            nxt = nxt + len;
         end
      end
   endtask

   task automatic predict_item();
      n_words = 0;
      if (!rst_sent && req_kind != KIND_NONE) begin
         case (req_kind)
            KIND_ACK:  on_ack(req_ack_number, req_peer_window, req_now_ms);
            KIND_TICK: on_tick(req_now_ms);
            default:   waiting = add_sat(waiting, {16'd0, req_offered_bytes});
         endcase
         if (!rst_sent) cut_segments(req_now_ms);
      end
      if (n_words == 0) push_word(ACT_NONE, 0, 0);
      item_words[n_words - 1].last = 1'b1;
      for (int i = 0; i < n_words; i++) expected_words.push_back(item_words[i]);
   endtask

   task automatic write_reg();
      case (csr_index)
         CSR_MSS: begin
            c_mss = {16'd0, csr_wdata[15:0]}; cwnd = c_mss; rwnd = c_mss;
         end
         CSR_INIT_SEQ: begin
            c_init_seq = csr_wdata; nxt = csr_wdata; una = csr_wdata;
         end
         CSR_INIT_RTO: begin
            c_init_rto = {16'd0, csr_wdata[15:0]}; est = c_init_rto; rto = c_init_rto;
         end
         CSR_PROBE:     c_probe = {16'd0, csr_wdata[15:0]};
         CSR_DUP_LIMIT: c_dup_limit = csr_wdata[3:0];
         default: ;
      endcase
   endtask

   initial begin
      clear_state();
      errors = 0;
   end

   // compare response words, then fold in the accepted request or write
   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         clear_state();
         expected_words.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("unexpected word: action %0d seq %h len %0d last %0d",
                           rsp_action, rsp_seq_number, rsp_seg_length, rsp_last);
            end else begin
               // oldest expected word
               w = expected_words[0];
               expected_words.delete(0);
               if (rsp_action !== w.action || rsp_seq_number !== w.seq ||
                   rsp_seg_length !== w.len || rsp_last !== w.last) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: exp action %0d seq %h len %0d last %0d, got %0d %h %0d %0d",
                              w.action, w.seq, w.len, w.last,
                              rsp_action, rsp_seq_number, rsp_seg_length, rsp_last);
               end
            end
         end
         if (csr_we) write_reg();
         if (start && !busy) predict_item();
      end
      pending  <= expected_words.size();
      snd_next <= nxt;
      snd_una  <= una;
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random ACK, tick and offer items through several
// register settings; the checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_top;
   import tswc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_kind = KIND_NONE;
   logic [31:0] req_ack_number = 0;
   logic [15:0] req_peer_window = 0;
   logic [15:0] req_offered_bytes = 0;
   logic [31:0] req_now_ms = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_seq_number;
   logic [15:0] rsp_seg_length;
   logic        rsp_last;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   int          errors, pending;
   logic [31:0] snd_next, snd_una;
   logic [31:0] now_ms = 0;
   int          cycles = 0;
   bit          gaps_on = 1;

   always #4 clock = ~clock;

   tcp_sender_window_controller u_dut (.*);

   tswc_checker u_checker (.*);

   // run length guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[tcp_sender_window_controller] ERROR");
         $finish;
      end
   end

   task automatic send_word(kind_type k, logic [31:0] ack, logic [15:0] win,
                            logic [15:0] offer);
      @(negedge clock);
      start = 1;
      req_kind = k;
      req_ack_number = ack;
      req_peer_window = win;
      req_offered_bytes = offer;
      req_now_ms = now_ms;
      do @(posedge clock); while (busy);
      // let the checker's view of the sender settle before the next word
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 99) < 25) begin
         start = 0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   endtask

   // let every expected word arrive and the block settle
   task automatic drain();
      @(negedge clock);
      start = 0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic new_ack(logic [15:0] win);
      logic [31:0] span;
      span = snd_next - snd_una;
      if (span == 0) send_word(KIND_ACK, snd_una, win, 0);
      else send_word(KIND_ACK, snd_una + $urandom_range(1, span), win, 0);
   endtask

   task automatic random_items(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         now_ms = now_ms + $urandom_range(0, 200);
         if (r < 28) begin
            send_word(KIND_OFFER, $urandom, 16'($urandom), 16'($urandom_range(1, 6000)));
         end else if (r < 48) begin
            new_ack(16'($urandom_range(1, 65535)));
         end else if (r < 60) begin
            // duplicate burst towards fast retransmit
            repeat ($urandom_range(1, 5))
               send_word(KIND_ACK, snd_una, 16'($urandom_range(1, 65535)), 0);
         end else if (r < 76) begin
            if ($urandom_range(0, 3) == 0) now_ms = now_ms + $urandom_range(0, 70000);
            send_word(KIND_TICK, $urandom, 16'($urandom), 16'($urandom));
         end else if (r < 84) begin
            // zero window then some ticks for probes
            send_word(KIND_ACK, snd_una, 0, 0);
            repeat ($urandom_range(1, 3)) begin
               now_ms = now_ms + $urandom_range(0, 3000);
               send_word(KIND_TICK, 0, 0, 0);
            end
            new_ack(16'($urandom_range(1, 65535)));
         end else if (r < 95) begin
            // stale ack with arbitrary content
            if ($urandom_range(0, 9) == 0) now_ms = $urandom;
            send_word(KIND_ACK, snd_una - $urandom_range(1, 32'h7FFF_FFFF), 16'($urandom),
                      16'($urandom));
         end else begin
            send_word(KIND_NONE, $urandom, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset settings
      send_word(KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_word(KIND_OFFER, 0, 0, 0);
      send_word(KIND_OFFER, 0, 0, 16'hFFFF);
      now_ms = 100;
      new_ack(16'hFFFF);
      send_word(KIND_ACK, snd_una, 16'hFFFF, 0);
      send_word(KIND_ACK, snd_una, 16'hFFFF, 0);
      send_word(KIND_ACK, snd_una, 16'hFFFF, 0);
      send_word(KIND_ACK, snd_una - 1, 16'hFFFF, 0);
      now_ms = 5000;
      send_word(KIND_TICK, 0, 0, 0);
      send_word(KIND_ACK, snd_una, 0, 0);
      now_ms = 7000;
      send_word(KIND_TICK, 0, 0, 0);
      now_ms = 7500;
      send_word(KIND_TICK, 0, 0, 0);
      now_ms = 10000;
      send_word(KIND_TICK, 0, 0, 0);
      send_word(KIND_ACK, snd_next, 16'hFFFF, 0);
      now_ms = 32'hFFFF_FFF0;
      send_word(KIND_TICK, 0, 0, 0);
      now_ms = 20;
      send_word(KIND_TICK, 0, 0, 0);
      random_items(15);
      drain();

      // tiny segments, fast timeouts, wrap of sequence space
      csr_write(CSR_MSS, 1);
      csr_write(CSR_INIT_SEQ, 32'hFFFF_FF00);
      csr_write(CSR_INIT_RTO, 1);
      csr_write(CSR_PROBE, 1);
      csr_write(CSR_DUP_LIMIT, 1);
      csr_write(3'd5, 32'hFFFF_FFFF);
      random_items(20);
      drain();

      // largest values, no gaps
      gaps_on = 0;
      csr_write(CSR_MSS, 32'h0000_FFFF);
      csr_write(CSR_INIT_SEQ, 32'h7FFF_FFF0);
      csr_write(CSR_INIT_RTO, 32'h0000_FFFF);
      csr_write(CSR_PROBE, 32'h0000_FFFF);
      csr_write(CSR_DUP_LIMIT, 15);
      csr_write(3'd7, 0);
      random_items(20);
      drain();
      gaps_on = 1;

      // zero mss and a dup limit that fires on wrap
      csr_write(CSR_MSS, 0);
      csr_write(CSR_DUP_LIMIT, 0);
      send_word(KIND_OFFER, 0, 0, 500);
      repeat (17) send_word(KIND_ACK, snd_una, 100, 0);
      random_items(6);
      drain();

      // ordinary settings
      csr_write(CSR_MSS, 536);
      csr_write(CSR_INIT_SEQ, $urandom);
      csr_write(CSR_INIT_RTO, 300);
      csr_write(CSR_PROBE, 200);
      csr_write(CSR_DUP_LIMIT, 3);
      random_items(20);

      // ack beyond next: reset word, then everything is ignored
      send_word(KIND_ACK, snd_next + $urandom_range(1, 1000), 16'hFFFF, 0);
      send_word(KIND_OFFER, 0, 0, 1000);
      send_word(KIND_TICK, 0, 0, 0);
      drain();

      if (errors == 0) begin
         $display("[tcp_sender_window_controller] OK");
      end else begin
         $display("[tcp_sender_window_controller] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/tswc_pkg.sv
rtl/core/tswc_seg_ram.sv
rtl/core/tswc_rtt.sv
rtl/core/tcp_sender_window_controller.sv
sim/tswc_checker.sv
sim/tb_top.sv
